>>> rtl/core/hfd_pkg.sv
// shared types and constants for the huffman tree decoder
`default_nettype none

package hfd_pkg;

	localparam int DEF_MAX_NODES  = 512;
	localparam int DEF_MAX_LEAVES = 256;

	localparam int LEAF_W  = 9;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 8;
	localparam int BITS_W  = 4;
	localparam int COUNT_W = 32;
	localparam int REQ_W   = 2;

	localparam logic [BITS_W-1:0] MAX_CODE_BITS = 4'd8;

	typedef enum logic [REQ_W-1:0] {
		REQ_LEAF  = 2'd0,
		REQ_NODE  = 2'd1,
		REQ_CODE  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef struct packed {
		logic leaf_wr;
		logic node_go;
		logic clear;
	} load_ctrl_t;

	typedef struct packed {
		logic go;
		logic clear;
	} walk_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/hfd_tree_store.sv
// node table storage: leaf flag and symbol, right links, cached root entry
`default_nettype none

module hfd_tree_store import hfd_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  wire logic             clk,
	input  wire logic             info_we,
	input  wire logic [NW-1:0]    info_addr,
	input  wire logic             info_leaf,
	input  wire logic [SYM_W-1:0] info_sym,
	input  wire logic             right_we,
	input  wire logic [NW-1:0]    right_addr,
	input  wire logic [NW-1:0]    right_data,
	input  wire logic [NW-1:0]    rd_addr,
	output logic                  rd_leaf,
	output logic [SYM_W-1:0]      rd_sym,
	output logic [NW-1:0]         rd_right,
	output logic                  root_leaf,
	output logic [SYM_W-1:0]      root_sym,
	output logic [NW-1:0]         root_right
);

	logic [SYM_W:0]   info_mem [MAX_NODES];
	logic [NW-1:0]    right_mem [MAX_NODES];
	logic [SYM_W:0]   info_rd_q;
	logic [NW-1:0]    right_rd_q;
	logic             root_leaf_q;
	logic [SYM_W-1:0] root_sym_q;
	logic [NW-1:0]    root_right_q;

	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_addr] <= {info_leaf, info_sym};
		end
		if (right_we) begin
			right_mem[right_addr] <= right_data;
		end
		info_rd_q  <= info_mem[rd_addr];
		right_rd_q <= right_mem[rd_addr];
		if (info_we && (info_addr == '0)) begin
			root_leaf_q <= info_leaf;
			root_sym_q  <= info_sym;
		end
		if (right_we && (right_addr == '0)) begin
			root_right_q <= right_data;
		end
	end

	assign rd_leaf    = info_rd_q[SYM_W];
	assign rd_sym     = info_rd_q[SYM_W-1:0];
	assign rd_right   = right_rd_q;
	assign root_leaf  = root_leaf_q;
	assign root_sym   = root_sym_q;
	assign root_right = root_right_q;

endmodule

`default_nettype wire

>>> rtl/core/hfd_loader.sv
// tree builder: leaf position list, pending right-child stack, preorder node insert
`default_nettype none

module hfd_loader import hfd_pkg::*; #(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int MAX_LEAVES = DEF_MAX_LEAVES,
	localparam int NW  = $clog2(MAX_NODES),
	localparam int NPW = $clog2(MAX_NODES + 1),
	localparam int LIW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1,
	localparam int LCW = $clog2(MAX_LEAVES + 1),
	localparam int SS  = (MAX_NODES + 1) / 2,
	localparam int SIW = (SS > 1) ? $clog2(SS) : 1,
	localparam int SCW = $clog2(SS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire load_ctrl_t        ctrl,
	input  wire logic [LEAF_W-1:0] leaf_position,
	input  wire logic [SYM_W-1:0]  node_byte,
	output logic                   info_we,
	output logic [NW-1:0]          info_addr,
	output logic                   info_leaf,
	output logic [SYM_W-1:0]       info_sym,
	output logic                   right_we,
	output logic [NW-1:0]          right_addr,
	output logic [NW-1:0]          right_data,
	output logic                   tree_complete
);

	logic [LEAF_W-1:0] leaf_mem [MAX_LEAVES];
	logic [NW-1:0]     stack_mem [SS];

	logic [LCW-1:0]    leaf_wr_cnt_q;
	logic [LCW-1:0]    leaf_rd_cnt_q;
	logic [NPW-1:0]    node_pos_q;
	logic [SCW-1:0]    depth_q;
	logic              last_leaf_q;
	logic              exec_q;
	logic [SYM_W-1:0]  byte_q;
	logic [LEAF_W-1:0] leaf_rd_q;
	logic [NW-1:0]     stack_rd_q;

	logic              complete;
	logic              do_node;
	logic              pop;
	logic              leaf_hit;
	logic              is_leaf;
	logic              push;
	logic              leaf_wr_en;
	logic [SCW-1:0]    depth_m1;
	logic [SCW-1:0]    depth_pop;

	always_comb begin
		complete   = (node_pos_q != '0) && last_leaf_q && (depth_q == '0);
		do_node    = exec_q && (node_pos_q < NPW'(MAX_NODES)) && !complete;
		pop        = do_node && (node_pos_q != '0) && last_leaf_q && (depth_q != '0);
		depth_m1   = depth_q - 1'b1;
		depth_pop  = pop ? depth_m1 : depth_q;
		leaf_hit   = (leaf_rd_cnt_q < LCW'(MAX_LEAVES)) &&
			(32'(leaf_rd_q) == 32'(node_pos_q));
		is_leaf    = (byte_q != '0) || leaf_hit;
		push       = do_node && !is_leaf && (depth_pop < SCW'(SS));
		leaf_wr_en = ctrl.leaf_wr && (leaf_wr_cnt_q < LCW'(MAX_LEAVES));
	end

	always_ff @(posedge clk) begin
		if (leaf_wr_en) begin
			leaf_mem[leaf_wr_cnt_q[LIW-1:0]] <= leaf_position;
		end
		leaf_rd_q <= leaf_mem[leaf_rd_cnt_q[LIW-1:0]];
		if (push) begin
			stack_mem[depth_pop[SIW-1:0]] <= node_pos_q[NW-1:0];
		end
		stack_rd_q <= stack_mem[depth_m1[SIW-1:0]];
		if (ctrl.node_go) begin
			byte_q <= node_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_wr_cnt_q <= '0;
			leaf_rd_cnt_q <= '0;
			node_pos_q    <= '0;
			depth_q       <= '0;
			last_leaf_q   <= 1'b0;
			exec_q        <= 1'b0;
		end else if (ctrl.clear) begin
			leaf_wr_cnt_q <= '0;
			leaf_rd_cnt_q <= '0;
			node_pos_q    <= '0;
			depth_q       <= '0;
			last_leaf_q   <= 1'b0;
			exec_q        <= 1'b0;
		end else begin
			exec_q <= ctrl.node_go;
			if (leaf_wr_en) begin
				leaf_wr_cnt_q <= leaf_wr_cnt_q + 1'b1;
			end
			if (do_node) begin
				node_pos_q  <= node_pos_q + 1'b1;
				last_leaf_q <= is_leaf;
				depth_q     <= push ? (depth_pop + 1'b1) : depth_pop;
				if (is_leaf) begin
					leaf_rd_cnt_q <= leaf_rd_cnt_q + 1'b1;
				end
			end
		end
	end

	assign info_we       = do_node;
	assign info_addr     = node_pos_q[NW-1:0];
	assign info_leaf     = is_leaf;
	assign info_sym      = byte_q;
	assign right_we      = pop;
	assign right_addr    = stack_rd_q;
	assign right_data    = node_pos_q[NW-1:0];
	assign tree_complete = complete;

endmodule

`default_nettype wire

>>> rtl/core/hfd_walker.sv
// bit-serial tree walk: one node step per cycle, symbol hold stage for last marking
`default_nettype none

module hfd_walker import hfd_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire walk_ctrl_t         ctrl,
	input  wire logic [CODE_W-1:0]  code_byte,
	input  wire logic [BITS_W-1:0]  code_bits,
	input  wire logic [COUNT_W-1:0] symbol_count,
	input  wire logic               root_leaf,
	input  wire logic [SYM_W-1:0]   root_sym,
	input  wire logic [NW-1:0]      root_right,
	input  wire logic               rd_leaf,
	input  wire logic [SYM_W-1:0]   rd_sym,
	input  wire logic [NW-1:0]      rd_right,
	output logic [NW-1:0]           rd_addr,
	output logic                    done,
	output logic                    strobe,
	output logic [SYM_W-1:0]        symbol,
	output logic                    last_of_run,
	output logic                    finished
);

	logic               run_q;
	logic               flush_q;
	logic               pend_rd_q;
	logic [NW-1:0]      rd_node_q;
	logic [NW-1:0]      cur_q;
	logic [NW-1:0]      cur_right_q;
	logic [BITS_W-1:0]  bit_idx_q;
	logic [BITS_W-1:0]  nbits_q;
	logic [CODE_W-1:0]  byte_q;
	logic [COUNT_W-1:0] emitted_q;
	logic               pend_v_q;
	logic [SYM_W-1:0]   pend_sym_q;
	logic               pend_fin_q;
	logic               strobe_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               last_q;
	logic               fin_q;

	logic               tree_emit;
	logic [NW-1:0]      ncur;
	logic [NW-1:0]      nright;
	logic [COUNT_W-1:0] cnt_after;
	logic               adv;
	logic               emit;
	logic               issue;
	logic [SYM_W-1:0]   emit_sym;
	logic               emit_fin;
	logic [NW:0]        inc_wide;
	logic [NW-1:0]      nxt;

	always_comb begin
		tree_emit = run_q && pend_rd_q && rd_leaf;
		if (pend_rd_q) begin
			ncur   = rd_leaf ? '0 : rd_node_q;
			nright = rd_leaf ? root_right : rd_right;
		end else begin
			ncur   = cur_q;
			nright = (cur_q == '0) ? root_right : cur_right_q;
		end
		cnt_after = emitted_q + COUNT_W'(tree_emit);
		adv       = run_q && (bit_idx_q < nbits_q) && (cnt_after < symbol_count);
		issue     = adv && !root_leaf;
		emit      = root_leaf ? adv : tree_emit;
		emit_sym  = root_leaf ? root_sym : rd_sym;
		emit_fin  = (emitted_q + 1'b1) == symbol_count;
		inc_wide  = {1'b0, ncur} + 1'b1;
		if (byte_q[bit_idx_q[2:0]]) begin
			nxt = nright;
		end else if (inc_wide >= (NW + 1)'(MAX_NODES)) begin
			nxt = '0;
		end else begin
			nxt = inc_wide[NW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			byte_q  <= code_byte;
			nbits_q <= (code_bits > MAX_CODE_BITS) ? MAX_CODE_BITS : code_bits;
		end
		if (run_q) begin
			rd_node_q   <= nxt;
			cur_right_q <= nright;
		end
		if (emit) begin
			pend_sym_q <= emit_sym;
			pend_fin_q <= emit_fin;
		end
		symbol_q <= pend_sym_q;
		fin_q    <= pend_fin_q;
		last_q   <= flush_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			flush_q   <= 1'b0;
			pend_rd_q <= 1'b0;
			cur_q     <= '0;
			bit_idx_q <= '0;
			emitted_q <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else if (ctrl.clear) begin
			run_q     <= 1'b0;
			flush_q   <= 1'b0;
			pend_rd_q <= 1'b0;
			cur_q     <= '0;
			bit_idx_q <= '0;
			emitted_q <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (ctrl.go) begin
				run_q     <= 1'b1;
				bit_idx_q <= '0;
				pend_rd_q <= 1'b0;
			end else if (run_q) begin
				pend_rd_q <= issue;
				cur_q     <= root_leaf ? '0 : ncur;
				if (adv) begin
					bit_idx_q <= bit_idx_q + 1'b1;
				end else begin
					run_q   <= 1'b0;
					flush_q <= 1'b1;
				end
				if (emit) begin
					emitted_q <= emitted_q + 1'b1;
					pend_v_q  <= 1'b1;
					strobe_q  <= pend_v_q;
				end
			end else if (flush_q) begin
				flush_q  <= 1'b0;
				pend_v_q <= 1'b0;
				strobe_q <= pend_v_q;
			end
		end
	end

	assign rd_addr     = nxt;
	assign done        = flush_q;
	assign strobe      = strobe_q;
	assign symbol      = symbol_q;
	assign last_of_run = last_q;
	assign finished    = fin_q;

endmodule

`default_nettype wire

>>> rtl/core/huffman_tree_decoder.sv
// huffman tree decoder top level: request sequencer, count register, unit wiring
//
// usage: load the tree, then feed packed code bytes through one request channel.
// an item is taken at a rising edge with start high and busy low; req_type picks
// its kind: leaf position, tree node byte, code byte, or clear and restart.
// leaf position and clear items complete at once and never raise busy.
// a node byte holds busy for one cycle while the node is inserted (one read of
// the leaf list and the pending stack, then one table write).
// a code byte with n valid bits (more than 8 count as 8) holds busy while the
// tree walk makes one node table read per bit, fewer once symbol_count is
// reached, plus one closing step and one step to release the held symbol. a
// code byte before the tree is complete is dropped without raising busy.
// results leave one per cycle on symbol, last_of_run and finished, marked by
// strobe; each symbol is held one step so that last_of_run can be set on the final
// symbol of the item, so the last result appears in the cycle after the busy window.
// the receiver cannot stall; results are never held back. the user must write
// symbol_count through cfg_wen / cfg_wdata only while idle; it is not enforced.
// reset clears all counters, the walk position and symbol_count; table contents
// are left as they are and are rewritten before use.
`default_nettype none

module huffman_tree_decoder import hfd_pkg::*; #(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [REQ_W-1:0]   req_type,
	input  wire logic [LEAF_W-1:0]  leaf_position,
	input  wire logic [SYM_W-1:0]   node_byte,
	input  wire logic [CODE_W-1:0]  code_byte,
	input  wire logic [BITS_W-1:0]  code_bits,
	input  wire logic               cfg_wen,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	output logic                    strobe,
	output logic [SYM_W-1:0]        symbol,
	output logic                    last_of_run,
	output logic                    finished
);

	localparam int NW = $clog2(MAX_NODES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_NODE = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] symbol_count_q;
	logic               accept;
	logic               tree_complete;
	logic               walk_done;
	load_ctrl_t         load_ctrl;
	walk_ctrl_t         walk_ctrl;

	logic               info_we;
	logic [NW-1:0]      info_addr;
	logic               info_leaf;
	logic [SYM_W-1:0]   info_sym;
	logic               right_we;
	logic [NW-1:0]      right_addr;
	logic [NW-1:0]      right_data;
	logic [NW-1:0]      rd_addr;
	logic               rd_leaf;
	logic [SYM_W-1:0]   rd_sym;
	logic [NW-1:0]      rd_right;
	logic               root_leaf;
	logic [SYM_W-1:0]   root_sym;
	logic [NW-1:0]      root_right;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		load_ctrl.leaf_wr = accept && (req_type == REQ_LEAF);
		load_ctrl.node_go = accept && (req_type == REQ_NODE);
		load_ctrl.clear   = accept && (req_type == REQ_CLEAR);
		walk_ctrl.go      = accept && (req_type == REQ_CODE) && tree_complete;
		walk_ctrl.clear   = load_ctrl.clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			symbol_count_q <= '0;
		end else begin
			if (cfg_wen) begin
				symbol_count_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (load_ctrl.node_go) begin
						state_q <= ST_NODE;
					end else if (walk_ctrl.go) begin
						state_q <= ST_WALK;
					end
				end
				ST_NODE: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	hfd_loader #(
		.MAX_NODES  (MAX_NODES),
		.MAX_LEAVES (MAX_LEAVES)
	) u_loader (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (load_ctrl),
		.leaf_position (leaf_position),
		.node_byte     (node_byte),
		.info_we       (info_we),
		.info_addr     (info_addr),
		.info_leaf     (info_leaf),
		.info_sym      (info_sym),
		.right_we      (right_we),
		.right_addr    (right_addr),
		.right_data    (right_data),
		.tree_complete (tree_complete)
	);

	hfd_tree_store #(
		.MAX_NODES (MAX_NODES)
	) u_store (
		.clk        (clk),
		.info_we    (info_we),
		.info_addr  (info_addr),
		.info_leaf  (info_leaf),
		.info_sym   (info_sym),
		.right_we   (right_we),
		.right_addr (right_addr),
		.right_data (right_data),
		.rd_addr    (rd_addr),
		.rd_leaf    (rd_leaf),
		.rd_sym     (rd_sym),
		.rd_right   (rd_right),
		.root_leaf  (root_leaf),
		.root_sym   (root_sym),
		.root_right (root_right)
	);

	hfd_walker #(
		.MAX_NODES (MAX_NODES)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (walk_ctrl),
		.code_byte    (code_byte),
		.code_bits    (code_bits),
		.symbol_count (symbol_count_q),
		.root_leaf    (root_leaf),
		.root_sym     (root_sym),
		.root_right   (root_right),
		.rd_leaf      (rd_leaf),
		.rd_sym       (rd_sym),
		.rd_right     (rd_right),
		.rd_addr      (rd_addr),
		.done         (walk_done),
		.strobe       (strobe),
		.symbol       (symbol),
		.last_of_run  (last_of_run),
		.finished     (finished)
	);

	a_node_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_NODE)) |=> (state_q == ST_NODE) ##1 (state_q == ST_IDLE))
		else $error("node insert did not take exactly one busy cycle");

	a_code_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_CODE) && !tree_complete) |=> !busy)
		else $error("code item before tree completion raised busy");

	a_strobe_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_WALK))
		else $error("result strobe outside a tree walk");

	a_walk_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && walk_done) |=> !busy)
		else $error("walk end did not release busy");

endmodule

`default_nettype wire
